@@ rtl/quicksort_batch_sorter_macros.svh @@
// ----------------------------------------------------------------------------
// Quicksort batch sorter assertion macros
// Implication checks on the clock and reset of the including module.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_BATCH_SORTER_MACROS_SVH
`define QUICKSORT_BATCH_SORTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QSB_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("quicksort batch sorter: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define QSB_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("quicksort batch sorter: next-cycle check failed");

`endif

@@ rtl/qsb_pkg.sv @@
// ----------------------------------------------------------------------------
// Quicksort batch sorter package
// Sizes, derived widths and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package qsb_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int STK_W       = 2 * IDX_W;

	typedef enum logic [13:0] {
		ST_IDLE      = 14'b00000000000001,
		ST_START     = 14'b00000000000010,
		ST_POP       = 14'b00000000000100,
		ST_STK_WAIT  = 14'b00000000001000,
		ST_PIV       = 14'b00000000010000,
		ST_RD_B      = 14'b00000000100000,
		ST_CMP_B     = 14'b00000001000000,
		ST_RD_A      = 14'b00000010000000,
		ST_CMP_A     = 14'b00000100000000,
		ST_PLACE     = 14'b00001000000000,
		ST_PUSH_L    = 14'b00010000000000,
		ST_EMIT_RD   = 14'b00100000000000,
		ST_EMIT_LD   = 14'b01000000000000,
		ST_EMIT_HOLD = 14'b10000000000000
	} state_t;

endpackage

`default_nettype wire

@@ rtl/quicksort_batch_sorter.sv @@
// ----------------------------------------------------------------------------
// Quicksort batch sorter
// Loads a batch of signed values, sorts it ascending with an in-place hole
// partition quicksort and streams the sorted batch out.
//
// Usage: input transactions carry value and last; each value is written to
// the element store. Once the store holds CAPACITY values,
// further values are discarded and the batch is flagged as dropped. The
// transaction with last set closes the batch and starts the sort; in_stall
// stays high from then until the final result has been taken.
// Each compare of the partition is a memory read, then a compare and write
// back; each range popped from the pending-range stack also passes through
// the pop, stack-wait, pivot, place and push states.
// Results leave from an output register; the next element is read only once
// the previous result has been taken. out_stall simply holds the register
// and the sequencer waits. The final result has last_res set, and every
// result of a batch carries the same dropped flag.
// Reset empties the batch and the output register; memory contents are not
// cleared because only entries written in the current batch are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quicksort_batch_sorter_macros.svh"

module quicksort_batch_sorter
	import qsb_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0]      sorted_value,
	output logic                               last_res,
	output logic                               dropped
);

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] depth_q;
	logic             ovf_q;
	logic             out_valid_q;

	logic signed [VALUE_WIDTH-1:0] pivot_q;
	logic signed [VALUE_WIDTH-1:0] sorted_value_q;
	logic                          last_res_q;
	logic                          dropped_q;
	logic [IDX_W-1:0]              lo_q;
	logic [IDX_W-1:0]              hi_q;
	logic [IDX_W-1:0]              a_q;
	logic [IDX_W-1:0]              b_q;
	logic [IDX_W-1:0]              k_q;

	logic                          e_we;
	logic [IDX_W-1:0]              e_waddr;
	logic [VALUE_WIDTH-1:0]        e_wdata;
	logic                          e_re;
	logic [IDX_W-1:0]              e_raddr;
	logic [VALUE_WIDTH-1:0]        e_rdata_raw;
	logic signed [VALUE_WIDTH-1:0] e_rdata;

	logic             s_we;
	logic [IDX_W-1:0] s_waddr;
	logic [STK_W-1:0] s_wdata;
	logic             s_re;
	logic [IDX_W-1:0] s_raddr;
	logic [STK_W-1:0] s_rdata;

	logic             in_acc;
	logic             out_acc;
	logic             has_room;
	logic             a_lt_b;
	logic             push_r;
	logic             push_l;
	logic             k_last;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] depth_m1;
	logic [IDX_W-1:0] a_inc;
	logic [IDX_W-1:0] a_dec;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_acc   = out_valid_q && !out_stall;

	assign sorted_value = sorted_value_q;
	assign last_res     = last_res_q;
	assign dropped      = dropped_q;

	assign e_rdata  = e_rdata_raw;
	assign has_room = (count_q < CNT_W'(CAPACITY));
	assign a_lt_b   = (a_q < b_q);
	assign cnt_m1   = count_q - CNT_W'(1);
	assign depth_m1 = depth_q - CNT_W'(1);
	assign a_inc    = a_q + IDX_W'(1);
	assign a_dec    = a_q - IDX_W'(1);
	assign push_r   = (({1'b0, a_q} + (IDX_W + 1)'(1)) < {1'b0, hi_q})
		&& (depth_q < CNT_W'(CAPACITY));
	assign push_l   = (({1'b0, lo_q} + (IDX_W + 1)'(1)) < {1'b0, a_q})
		&& (depth_q < CNT_W'(CAPACITY));
	assign k_last   = ({1'b0, k_q} + CNT_W'(1)) == count_q;

	qsb_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_element_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(e_waddr),
		.wdata(e_wdata),
		.re   (e_re),
		.raddr(e_raddr),
		.rdata(e_rdata_raw)
	);

	qsb_ram #(
		.WIDTH(STK_W),
		.DEPTH(CAPACITY)
	) u_stack_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.re   (s_re),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	always_comb begin
		e_we    = 1'b0;
		e_waddr = '0;
		e_wdata = '0;
		e_re    = 1'b0;
		e_raddr = '0;
		s_we    = 1'b0;
		s_waddr = '0;
		s_wdata = '0;
		s_re    = 1'b0;
		s_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && has_room) begin
					e_we    = 1'b1;
					e_waddr = count_q[IDX_W-1:0];
					e_wdata = value;
				end
			end
			ST_START: begin
				if (count_q > CNT_W'(1)) begin
					s_we    = 1'b1;
					s_waddr = '0;
					s_wdata = {IDX_W'(0), cnt_m1[IDX_W-1:0]};
				end
			end
			ST_POP: begin
				if (depth_q != '0) begin
					s_re    = 1'b1;
					s_raddr = depth_m1[IDX_W-1:0];
				end
			end
			ST_STK_WAIT: begin
				e_re    = 1'b1;
				e_raddr = s_rdata[STK_W-1:IDX_W];
			end
			ST_RD_B: begin
				if (a_lt_b) begin
					e_re    = 1'b1;
					e_raddr = b_q;
				end
			end
			ST_CMP_B: begin
				if (!(e_rdata > pivot_q)) begin
					e_we    = 1'b1;
					e_waddr = a_q;
					e_wdata = e_rdata;
				end
			end
			ST_RD_A: begin
				if (a_lt_b) begin
					e_re    = 1'b1;
					e_raddr = a_q;
				end
			end
			ST_CMP_A: begin
				if (!(e_rdata < pivot_q)) begin
					e_we    = 1'b1;
					e_waddr = b_q;
					e_wdata = e_rdata;
				end
			end
			ST_PLACE: begin
				e_we    = 1'b1;
				e_waddr = a_q;
				e_wdata = pivot_q;
				if (push_r) begin
					s_we    = 1'b1;
					s_waddr = depth_q[IDX_W-1:0];
					s_wdata = {a_inc, hi_q};
				end
			end
			ST_PUSH_L: begin
				if (push_l) begin
					s_we    = 1'b1;
					s_waddr = depth_q[IDX_W-1:0];
					s_wdata = {lo_q, a_dec};
				end
			end
			ST_EMIT_RD: begin
				e_re    = 1'b1;
				e_raddr = k_q;
			end
			ST_EMIT_LD, ST_PIV, ST_EMIT_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			depth_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					depth_q <= (count_q > CNT_W'(1)) ? CNT_W'(1) : CNT_W'(0);
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (depth_q == '0) begin
						state_q <= ST_EMIT_RD;
					end else begin
						depth_q <= depth_m1;
						state_q <= ST_STK_WAIT;
					end
				end
				ST_STK_WAIT: state_q <= ST_PIV;
				ST_PIV:      state_q <= ST_RD_B;
				ST_RD_B:     state_q <= a_lt_b ? ST_CMP_B : ST_PLACE;
				ST_CMP_B:    state_q <= (e_rdata > pivot_q) ? ST_RD_B : ST_RD_A;
				ST_RD_A:     state_q <= a_lt_b ? ST_CMP_A : ST_PLACE;
				ST_CMP_A:    state_q <= (e_rdata < pivot_q) ? ST_RD_A : ST_RD_B;
				ST_PLACE: begin
					if (push_r) begin
						depth_q <= depth_q + CNT_W'(1);
					end
					state_q <= ST_PUSH_L;
				end
				ST_PUSH_L: begin
					if (push_l) begin
						depth_q <= depth_q + CNT_W'(1);
					end
					state_q <= ST_POP;
				end
				ST_EMIT_RD: state_q <= ST_EMIT_LD;
				ST_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT_HOLD;
				end
				ST_EMIT_HOLD: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (last_res_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_STK_WAIT: begin
				lo_q <= s_rdata[STK_W-1:IDX_W];
				hi_q <= s_rdata[IDX_W-1:0];
			end
			ST_PIV: begin
				pivot_q <= e_rdata;
				a_q     <= lo_q;
				b_q     <= hi_q;
			end
			ST_CMP_B: begin
				if (e_rdata > pivot_q) begin
					b_q <= b_q - IDX_W'(1);
				end else begin
					a_q <= a_inc;
				end
			end
			ST_CMP_A: begin
				if (e_rdata < pivot_q) begin
					a_q <= a_inc;
				end else begin
					b_q <= b_q - IDX_W'(1);
				end
			end
			ST_POP: begin
				k_q <= '0;
			end
			ST_EMIT_LD: begin
				sorted_value_q <= e_rdata;
				last_res_q     <= k_last;
				dropped_q      <= ovf_q;
			end
			ST_EMIT_HOLD: begin
				if (out_acc) begin
					k_q <= k_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	`QSB_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`QSB_ASSERT_IMPL(a_scan_window, (state_q == ST_RD_B) || (state_q == ST_RD_A),
		(a_q <= b_q) && (lo_q <= a_q) && (b_q <= hi_q))
	`QSB_ASSERT_NEXT(a_batch_start, in_acc && last, state_q == ST_START)
	`QSB_ASSERT_NEXT(a_batch_end, out_acc && last_res,
		(state_q == ST_IDLE) && (count_q == '0) && !ovf_q)
	`QSB_ASSERT_IMPL(a_emit_only, out_valid_q, state_q == ST_EMIT_HOLD)

endmodule

`default_nettype wire

@@ rtl/qsb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module qsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
